// ----- rtl/core/wpam_pkg.sv -----
// Package for the windowed peak acceleration magnitude block.
// Holds beat structs, the controller state type and reset constants.
// No dependencies.
`default_nettype none

package wpam_pkg;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SquareW = 32;
  localparam int unsigned MagW   = 16;
  localparam int unsigned CountW = 16;

  // Window limit after reset: 5 * 13 samples.
  localparam logic [CountW-1:0] WINDOW_LIMIT_RST = CountW'(5 * 13);

  typedef struct packed {
    logic signed [AxisW-1:0] accel_x;
    logic signed [AxisW-1:0] accel_y;
    logic signed [AxisW-1:0] accel_z;
    logic [TimeW-1:0]        batch_time;
    logic                    batch_last;
  } accel_in_t;

  typedef struct packed {
    logic [MagW-1:0]  peak_magnitude;
    logic [TimeW-1:0] peak_time;
  } peak_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } wpam_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/wpam_sumsq.sv -----
// Bit-serial sum of squares x^2 + y^2 + z^2, one multiplier bit per cycle.
// Depends on wpam_pkg.
`default_nettype none

module wpam_sumsq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wpam_pkg::AxisW-1:0]   x_i,
  input  logic signed [wpam_pkg::AxisW-1:0]   y_i,
  input  logic signed [wpam_pkg::AxisW-1:0]   z_i,
  output logic                                done_o,
  output logic [wpam_pkg::SquareW-1:0]        sum_o
);
  import wpam_pkg::*;

  logic [AxisW-1:0]   mx_q, my_q, mz_q;   // multiplicands
  logic [AxisW-1:0]   sx_q, sy_q, sz_q;   // multipliers, shifted out MSB first
  logic [SquareW-1:0] acc_q, acc_d;
  logic [3:0]         cnt_q;
  logic               busy_q, done_q;
  logic [AxisW+1:0]   addend;
  logic [AxisW-1:0]   ax, ay, az;

  // Magnitude of a signed axis; -32768 maps to 32768, which fits unsigned.
  assign ax = x_i[AxisW-1] ? AxisW'(~x_i + 1'b1) : AxisW'(x_i);
  assign ay = y_i[AxisW-1] ? AxisW'(~y_i + 1'b1) : AxisW'(y_i);
  assign az = z_i[AxisW-1] ? AxisW'(~z_i + 1'b1) : AxisW'(z_i);

  assign addend = (sx_q[AxisW-1] ? (AxisW+2)'(mx_q) : '0)
                + (sy_q[AxisW-1] ? (AxisW+2)'(my_q) : '0)
                + (sz_q[AxisW-1] ? (AxisW+2)'(mz_q) : '0);
  assign acc_d  = {acc_q[SquareW-2:0], 1'b0} + SquareW'(addend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'hF);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'hF) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q  <= ax;
      my_q  <= ay;
      mz_q  <= az;
      sx_q  <= ax;
      sy_q  <= ay;
      sz_q  <= az;
      acc_q <= '0;
    end else if (busy_q) begin
      sx_q  <= {sx_q[AxisW-2:0], 1'b0};
      sy_q  <= {sy_q[AxisW-2:0], 1'b0};
      sz_q  <= {sz_q[AxisW-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/wpam_isqrt.sv -----
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on wpam_pkg.
`default_nettype none

module wpam_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wpam_pkg::SquareW-1:0]  op_i,
  output logic                          done_o,
  output logic [wpam_pkg::MagW-1:0]     root_o
);
  import wpam_pkg::*;

  localparam int unsigned RemW = MagW + 3;

  logic [SquareW-1:0] op_q;
  logic [RemW-1:0]    rem_q, rem_sh, trial;
  logic [MagW-1:0]    root_q;
  logic [3:0]         cnt_q;
  logic               busy_q, done_q;
  logic               fits;

  // Remainder stays below 2^17, so the top bits drop cleanly on the shift.
  assign rem_sh = {rem_q[RemW-3:0], op_q[SquareW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'hF);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'hF) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[SquareW-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[MagW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- rtl/core/windowed_peak_accel_magnitude_top.sv -----
// Windowed peak acceleration magnitude: top level with controller and state.
// Depends on wpam_pkg, wpam_sumsq and wpam_isqrt.
// An input beat reaches the window decision when the serial squarer is done;
// an emitted beat then passes through the serial root to the output, later
// while the previous result still waits for out_ready_i.
// A new input beat is taken only once the previous one is through the 16-step
// serial squarer; a beat that closes the window also waits for the serial root.
// Reset: count and peak clear, window limit returns to 65, no output pending.
`default_nettype none

module windowed_peak_accel_magnitude_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wpam_pkg::accel_in_t           in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wpam_pkg::peak_out_t           out_data_o,
  // window limit register
  input  logic                          cfg_we_i,
  input  logic [wpam_pkg::CountW-1:0]   cfg_wdata_i
);
  import wpam_pkg::*;

  wpam_state_e        state_q, state_d;

  logic [CountW-1:0]  limit_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [SquareW-1:0] peak_q, peak_d;
  logic [TimeW-1:0]   time_q;       // timestamp of the beat in flight
  logic               last_q;       // batch_last of the beat in flight

  logic               out_valid_q;
  peak_out_t          out_q;

  logic               in_beat;
  logic               sq_done, root_done, root_start;
  logic [SquareW-1:0] sq_sum, peak_new;
  logic [MagW-1:0]    root;
  logic               emit;
  logic               out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  // Serial squarer: starts on the accepted beat.
  wpam_sumsq u_sumsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_beat),
    .x_i     (in_data_i.accel_x),
    .y_i     (in_data_i.accel_y),
    .z_i     (in_data_i.accel_z),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  // Running max including this beat's square.
  assign peak_new = (sq_sum > peak_q) ? sq_sum : peak_q;
  // Count was already bumped at accept time, so compare it as is.
  assign emit     = last_q && (count_q > limit_q);

  // Serial root of the closing peak; the value is latched inside the unit,
  // so the peak register may clear on the same edge.
  wpam_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .op_i    (peak_new),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Controller
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    peak_d     = peak_q;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          // saturating sample counter
          if (count_q != '1) begin
            count_d = count_q + CountW'(1);
          end
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          if (emit) begin
            root_start = 1'b1;
            count_d    = '0;
            peak_d     = '0;
            state_d    = ST_ROOT;
          end else begin
            peak_d  = peak_new;
            state_d = ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= WINDOW_LIMIT_RST;
      count_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      time_q <= in_data_i.batch_time;
      last_q <= in_data_i.batch_last;
    end
    if (out_load) begin
      out_q.peak_magnitude <= root;
      out_q.peak_time      <= time_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_sq_done_in_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQ))
    else $error("squarer finished outside the square state");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == ST_ROOT))
    else $error("root unit finished outside the root state");

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ && sq_done && emit) |=> (count_q == '0 && peak_q == '0))
    else $error("window state not cleared after emission");

  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ && sq_done && !emit) |=>
      (peak_q >= $past(sq_sum) && peak_q >= $past(peak_q)))
    else $error("peak lost a larger square");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
